>>> design/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes for the sequential list engine: operation and
// status codes, and the transaction token that travels down the cell chain.
// ----------------------------------------------------------------------------
package sle_pkg;

    // Default list capacity and the widest capacity the token is sized for
    localparam int SLE_CAPACITY     = 16;
    localparam int SLE_CAPACITY_MAX = 256;

    // Token field widths, sized for the widest capacity
    localparam int IDX_W = $clog2(SLE_CAPACITY_MAX);
    localparam int CNT_W = $clog2(SLE_CAPACITY_MAX + 1);

    // Fixed field widths of the stream payload
    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;
    localparam int LEN_W  = 5;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_GET    = 3'd3;
    localparam logic [OP_W-1:0] OP_LOCATE = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    // What the cells do as a token passes
    typedef enum logic [2:0] {
        TK_NONE   = 3'd0,
        TK_INSERT = 3'd1,
        TK_DELETE = 3'd2,
        TK_READ   = 3'd3,
        TK_LOCATE = 3'd4
    } tok_kind_t;

    // One transaction in flight along the chain
    typedef struct packed {
        logic                     valid;
        tok_kind_t                kind;
        logic [IDX_W-1:0]         idx;     // 0-based target cell
        logic [CNT_W-1:0]         limit;   // entry count before the operation
        logic [CNT_W-1:0]         length;  // entry count after the operation
        logic [STAT_W-1:0]        status;
        logic signed [VAL_W-1:0]  value;
        logic signed [VAL_W-1:0]  carry;   // entry shifted up by an insert
        logic signed [VAL_W-1:0]  rdata;
        logic                     found;
        logic [CNT_W-1:0]         found_pos;
    } token_t;

endpackage

>>> design/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell
// One list slot. Holds a single entry and applies the transaction token as
// it passes, then hands the token to the next cell.
// ----------------------------------------------------------------------------
module sle_cell
    import sle_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  token_t                  tok_in,
    input  logic signed [VAL_W-1:0] right_entry,
    output token_t                  tok_out,
    output logic signed [VAL_W-1:0] entry
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX + 1);

    token_t                  tok_reg;
    token_t                  tok_next;
    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;

    // Apply the incoming token to this slot
    always_comb
    begin
        tok_next   = tok_in;
        entry_next = entry_reg;
        case (tok_in.kind)
            TK_INSERT:
            begin
                if (tok_in.idx == MY_IDX)
                begin
                    entry_next    = tok_in.value;
                    tok_next.carry = entry_reg;
                end
                else if (MY_IDX > tok_in.idx)
                begin
                    entry_next    = tok_in.carry;
                    tok_next.carry = entry_reg;
                end
            end
            TK_DELETE:
            begin
                if (tok_in.idx == MY_IDX)
                    tok_next.rdata = entry_reg;
                if (MY_IDX >= tok_in.idx)
                    entry_next = right_entry;
            end
            TK_READ:
            begin
                if (tok_in.idx == MY_IDX)
                    tok_next.rdata = entry_reg;
            end
            TK_LOCATE:
            begin
                if (!tok_in.found && (MY_CNT < tok_in.limit) && (entry_reg == tok_in.value))
                begin
                    tok_next.found     = 1'b1;
                    tok_next.found_pos = MY_POS;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Token stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else if (adv)
            tok_reg <= tok_next;
    end

    // Entry storage, written only as a token passes
    always_ff @(posedge clk)
    begin
        if (adv && tok_in.valid)
            entry_reg <= entry_next;
    end

    assign tok_out = tok_reg;
    assign entry   = entry_reg;

endmodule

>>> design/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// Issue and retire control: checks each operation against the entry count,
// launches a token into the cell chain and holds the finished result.
// ----------------------------------------------------------------------------
module sle_ctrl
    import sle_pkg::*;
#(
    parameter int CAPACITY = SLE_CAPACITY
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output token_t              launch,
    input  token_t              last,
    output logic                adv
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_W = CNT_W'(CAPACITY);

    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    logic [CNT_W-1:0]        pos_w;
    logic [CNT_W-1:0]        cnt_w;
    logic                    accept;
    logic                    retire;

    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic                    inflight_reg;
    logic                    inflight_next;
    token_t                  launch_reg;
    token_t                  launch_next;
    token_t                  issue_tok;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [M_DATA_W-1:0]     out_data_reg;
    logic [M_DATA_W-1:0]     out_data_next;
    logic [STAT_W-1:0]       ret_status;

    assign op     = s_tdata[2:0];
    assign pos    = s_tdata[7:3];
    assign val    = s_tdata[39:8];
    assign pos_w  = CNT_W'(pos);
    assign cnt_w  = CNT_W'(count_reg);

    assign s_tready = !inflight_reg;
    assign accept   = s_tvalid && !inflight_reg;

    // Chain moves unless the finished token has nowhere to go
    assign adv    = !(last.valid && out_valid_reg && !m_tready);
    assign retire = last.valid && adv;

    // Decode and check the incoming operation
    always_comb
    begin
        issue_tok           = '0;
        issue_tok.valid     = 1'b1;
        issue_tok.kind      = TK_NONE;
        issue_tok.idx       = IDX_W'(pos - 5'd1);
        issue_tok.limit     = cnt_w;
        issue_tok.status    = ST_OK;
        issue_tok.value     = val;
        count_next          = count_reg;
        unique case (op)
            OP_CLEAR:
                count_next = '0;
            OP_INSERT:
            begin
                if (cnt_w >= CAP_W)
                    issue_tok.status = ST_FULL;
                else if ((pos_w == '0) || (pos_w > (cnt_w + 1'b1)))
                    issue_tok.status = ST_BADPOS;
                else
                begin
                    issue_tok.kind = TK_INSERT;
                    count_next     = CW'(count_reg + 1'b1);
                end
            end
            OP_DELETE:
            begin
                if (cnt_w == '0)
                    issue_tok.status = ST_EMPTY;
                else if ((pos_w == '0) || (pos_w > cnt_w))
                    issue_tok.status = ST_BADPOS;
                else
                begin
                    issue_tok.kind = TK_DELETE;
                    count_next     = CW'(count_reg - 1'b1);
                end
            end
            OP_GET:
            begin
                if ((pos_w == '0) || (pos_w > cnt_w))
                    issue_tok.status = ST_BADPOS;
                else
                    issue_tok.kind = TK_READ;
            end
            OP_LOCATE:
            begin
                issue_tok.kind   = TK_LOCATE;
                issue_tok.status = ST_NOTFOUND;
            end
            default:
            begin
            end
        endcase
        issue_tok.length = CNT_W'(count_next);
    end

    // Launch stage feeding the first cell
    always_comb
    begin
        launch_next = launch_reg;
        if (accept)
            launch_next = issue_tok;
        else if (adv)
            launch_next.valid = 1'b0;
    end

    // One transaction in flight from acceptance until its result is stored
    always_comb
    begin
        inflight_next = inflight_reg;
        if (accept)
            inflight_next = 1'b1;
        else if (retire)
            inflight_next = 1'b0;
    end

    // Result register
    always_comb
    begin
        ret_status = last.status;
        if ((last.kind == TK_LOCATE) && last.found)
            ret_status = ST_OK;
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg;
        if (retire)
        begin
            out_data_next  = {3'b000, last.length[LEN_W-1:0], last.found_pos[POS_W-1:0],
                              last.rdata, ret_status};
            out_valid_next = 1'b1;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            inflight_reg  <= 1'b0;
            launch_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            inflight_reg  <= inflight_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign launch   = launch_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> design/sequential_list_engine.sv
// ----------------------------------------------------------------------------
// sequential_list_engine
// A token passes the launch register and then every cell of the chain, one
// cell a cycle while the chain is not stalled by an unread result, before its
// result is stored for m_tvalid; the next transaction is accepted only then.
// Reset: asynchronous, active low; the list is empty, entries are unset.
// Bounded ordered list of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
module sequential_list_engine
    import sle_pkg::*;
#(
    parameter int CAPACITY = SLE_CAPACITY
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [2:0] operation, [7:3] position, [39:8] value
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [2:0] status, [34:3] read_value, [39:35] found_position,
    // [44:40] list_length, [47:45] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    token_t                  tok_chain [0:CAPACITY];
    logic signed [VAL_W-1:0] entry_w   [0:CAPACITY-1];
    logic                    adv;

    // Issue and retire control
    sle_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .launch   (tok_chain[0]),
        .last     (tok_chain[CAPACITY]),
        .adv      (adv)
    );

    // Row of list cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] right_w;

        if (i == CAPACITY - 1)
        begin : g_end
            assign right_w = '0;
        end
        else
        begin : g_mid
            assign right_w = entry_w[i+1];
        end

        sle_cell #(
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .adv         (adv),
            .tok_in      (tok_chain[i]),
            .right_entry (right_w),
            .tok_out     (tok_chain[i+1]),
            .entry       (entry_w[i])
        );
    end

endmodule
